// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the rtl files, included by the top level
// each property is sampled on clk and disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define MDAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MDAC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define MDAC_ASSERT(lbl, prop, msg)
`define MDAC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ----- hw/rtl/mdac_pkg.sv -----
// shared types and constants for the row-major address calculator
// no dependencies
`timescale 1ns / 1ps

package mdac_pkg;

  localparam int MAX_ARRAYS_DEF = 16;
  localparam int MAX_DIMS_DEF   = 16;

  typedef enum logic [1:0] {
    FUNC_HEADER = 2'd0,
    FUNC_BOUNDS = 2'd1,
    FUNC_INDEX  = 2'd2
  } func_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic fold;
    logic accum;
    logic scale;
    logic emit;
  } ctl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic start_index;
    logic dim_ok;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/mdac_item_if.sv -----
// input channel: valid/ready handshake carrying one request item
// no dependencies
`timescale 1ns / 1ps

interface mdac_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [3:0]  array_id;
  logic [3:0]  dim_index;
  logic [31:0] base_address;
  logic [15:0] element_size;
  logic [4:0]  dim_count;
  logic signed [15:0] lower_bound;
  logic signed [15:0] upper_bound;
  logic signed [15:0] index_value;

  modport source (
    output valid, func, array_id, dim_index, base_address, element_size,
           dim_count, lower_bound, upper_bound, index_value,
    input  ready
  );
  modport sink (
    input  valid, func, array_id, dim_index, base_address, element_size,
           dim_count, lower_bound, upper_bound, index_value,
    output ready
  );
endinterface

// ----- hw/rtl/mdac_result_if.sv -----
// output channel: valid/ready handshake carrying one address item
// no dependencies
`timescale 1ns / 1ps

interface mdac_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic [3:0]  out_array_id;

  modport source (output valid, address, out_array_id, input ready);
  modport sink (input valid, address, out_array_id, output ready);
endinterface

// ----- hw/rtl/mdac_datapath.sv -----
// datapath: descriptor tables, bound memories, shared multiplier, horner
// accumulator and output register; depends on mdac_pkg
`timescale 1ns / 1ps

module mdac_datapath #(
  parameter int MAX_ARRAYS = 16,
  parameter int MAX_DIMS   = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mdac_pkg::ctl_cmd_t    cmd,
  output mdac_pkg::dp_status_t  status,
  input  logic [1:0]            func,
  input  logic [3:0]            array_id,
  input  logic [3:0]            dim_index,
  input  logic [31:0]           base_address,
  input  logic [15:0]           element_size,
  input  logic [4:0]            dim_count,
  input  logic signed [15:0]    lower_bound,
  input  logic signed [15:0]    upper_bound,
  input  logic signed [15:0]    index_value,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [31:0]           address,
  output logic [3:0]            out_array_id
);
  import mdac_pkg::*;

  localparam int AW    = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
  localparam int SLOTS = MAX_ARRAYS * MAX_DIMS;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NW    = ($clog2(MAX_DIMS + 1) > 5) ? $clog2(MAX_DIMS + 1) : 5;

  logic [31:0] base_mem  [MAX_ARRAYS];
  logic [15:0] size_mem  [MAX_ARRAYS];
  logic [4:0]  dims_mem  [MAX_ARRAYS];
  logic [15:0] lower_mem [SLOTS];
  logic [15:0] upper_mem [SLOTS];

  logic          arr_ok;
  logic          dim_in_table;
  logic [AW-1:0] arr_idx;
  logic [SW-1:0] slot;

  logic [31:0] base_rd;
  logic [15:0] size_rd;
  logic [4:0]  dims_rd;
  logic [15:0] lo_rd;
  logic [15:0] hi_rd;
  logic [3:0]  arr_q;
  logic [3:0]  dim_q;
  logic [15:0] idx_q;

  logic [NW-1:0] dims_eff;
  logic          dim_ok;
  logic          last;
  logic [31:0]   lo32;
  logic [31:0]   hi32;
  logic [31:0]   idx32;
  logic [31:0]   extent;
  logic [31:0]   term_next;
  logic [31:0]   mul_b;
  logic          out_free;

  logic [31:0] prod;
  logic [31:0] term;
  logic [31:0] acc;
  logic        last_q;
  logic        first_q;

  assign arr_ok       = 32'(array_id) < MAX_ARRAYS;
  assign dim_in_table = 32'(dim_index) < MAX_DIMS;
  assign arr_idx      = AW'(array_id);
  assign slot         = SW'(32'(arr_idx) * MAX_DIMS + 32'(dim_index));

  // table writes and registered reads, all launched by the accepted item
  always_ff @(posedge clk) begin
    if (cmd.accept && arr_ok) begin
      case (func_t'(func))
        FUNC_HEADER: begin
          base_mem[arr_idx] <= base_address;
          size_mem[arr_idx] <= element_size;
          dims_mem[arr_idx] <= dim_count;
        end
        FUNC_BOUNDS: begin
          if (dim_in_table) begin
            lower_mem[slot] <= lower_bound;
            upper_mem[slot] <= upper_bound;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      base_rd <= base_mem[arr_idx];
      size_rd <= size_mem[arr_idx];
      dims_rd <= dims_mem[arr_idx];
      lo_rd   <= lower_mem[slot];
      hi_rd   <= upper_mem[slot];
      arr_q   <= array_id;
      dim_q   <= dim_index;
      idx_q   <= index_value;
    end
  end

  // a stored count of zero acts as one, above the table depth it saturates
  always_comb begin
    dims_eff = NW'(dims_rd);
    if (dims_rd == 5'd0) begin
      dims_eff = NW'(1);
    end else if (NW'(dims_rd) > NW'(MAX_DIMS)) begin
      dims_eff = NW'(MAX_DIMS);
    end
  end

  assign dim_ok    = NW'(dim_q) < dims_eff;
  assign last      = (NW'(dim_q) + NW'(1)) == dims_eff;
  assign lo32      = {{16{lo_rd[15]}}, lo_rd};
  assign hi32      = {{16{hi_rd[15]}}, hi_rd};
  assign idx32     = {{16{idx_q[15]}}, idx_q};
  assign extent    = hi32 - lo32 + 32'd1;
  assign term_next = idx32 - lo32;

  // one multiplier, shared between the fold step and the final scaling
  assign mul_b = cmd.scale ? {16'd0, size_rd} : extent;

  always_ff @(posedge clk) begin
    if (cmd.fold || cmd.scale) begin
      prod <= acc * mul_b;
    end
    if (cmd.fold) begin
      term    <= term_next;
      last_q  <= last;
      first_q <= (dim_q == 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 32'd0;
    end else if (cmd.accum) begin
      acc <= first_q ? term : prod + term;
    end else if (cmd.scale) begin
      acc <= 32'd0;
    end
  end

  assign out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit && out_free) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && out_free) begin
      address      <= base_rd + prod;
      out_array_id <= arr_q;
    end
  end

  assign status.start_index = arr_ok && (func_t'(func) == FUNC_INDEX);
  assign status.dim_ok      = dim_ok;
  assign status.last        = last_q;
  assign status.out_free    = out_free;

endmodule

// ----- hw/rtl/mdac_ctrl.sv -----
// controller: sequences the index fold, scaling and emission of one item
// depends on mdac_pkg
`timescale 1ns / 1ps

module mdac_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mdac_pkg::dp_status_t status,
  output mdac_pkg::ctl_cmd_t   cmd
);
  import mdac_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLD,
    S_ACC,
    S_SCALE,
    S_EMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          // header and bound items finish in the accept cycle
          if (in_valid && status.start_index) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          state <= status.dim_ok ? S_ACC : S_IDLE;
        end
        S_ACC: begin
          state <= status.last ? S_SCALE : S_IDLE;
        end
        S_SCALE: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign cmd.accept = in_valid && in_ready;
  assign cmd.fold   = (state == S_FOLD);
  assign cmd.accum  = (state == S_ACC);
  assign cmd.scale  = (state == S_SCALE);
  assign cmd.emit   = (state == S_EMIT);

endmodule

// ----- hw/rtl/multidim_array_address_calc.sv -----
// channel  dir  payload
// item     in   func, array_id, dim_index, base_address, element_size,
//               dim_count, lower_bound, upper_bound, index_value
// result   out  address, out_array_id
//
// header and bound items finish in the accept cycle; an index component does a
// table read, multiply and accumulate, or skips the accumulate when its dimension
// is past the count; the last one also scales on the one shared 32x32 multiplier.
// rst clears the controller, the accumulator and the result valid; the tables
// hold garbage until written. the result sits in an output register, so a
// stalled result only holds the block when the next address is ready to go.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multidim_array_address_calc #(
  parameter int MAX_ARRAYS = mdac_pkg::MAX_ARRAYS_DEF,
  parameter int MAX_DIMS   = mdac_pkg::MAX_DIMS_DEF
) (
  input logic          clk,
  input logic          rst,
  mdac_item_if.sink    item,
  mdac_result_if.source result
);
  import mdac_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       in_ready;

  mdac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mdac_datapath #(
    .MAX_ARRAYS (MAX_ARRAYS),
    .MAX_DIMS   (MAX_DIMS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .func         (item.func),
    .array_id     (item.array_id),
    .dim_index    (item.dim_index),
    .base_address (item.base_address),
    .element_size (item.element_size),
    .dim_count    (item.dim_count),
    .lower_bound  (item.lower_bound),
    .upper_bound  (item.upper_bound),
    .index_value  (item.index_value),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .address      (result.address),
    .out_array_id (result.out_array_id)
  );

  assign item.ready = in_ready;

  // only one phase of the sequence is active at a time
  `MDAC_ASSERT(a_one_phase, $onehot0({in_ready, cmd.fold, cmd.accum, cmd.scale, cmd.emit}), "phase overlap")
  `MDAC_ASSERT_NEXT(a_fold_acc, cmd.fold && status.dim_ok, cmd.accum, "fold not followed by accumulate")
  `MDAC_ASSERT_NEXT(a_scale_emit, cmd.scale, cmd.emit, "scale not followed by emit")
  `MDAC_ASSERT_NEXT(a_emit_valid, cmd.emit && status.out_free, result.valid, "emitted address not shown")

endmodule
